/* rtl/oai_pkg.sv */
`timescale 1ns / 1ps
package oai_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int POS_W        = 9;
  localparam int STAT_W       = 2;
  localparam int IDX_W        = 9;
  localparam int CNT_W        = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND,
    REQ_INSERT,
    REQ_REMOVE,
    REQ_FIND
  } oai_req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_NOTFOUND
  } oai_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_DOWN,
    S_FIND,
    S_DONE
  } oai_state_t;

endpackage

/* rtl/oai_mem.sv */
`timescale 1ns / 1ps
module oai_mem #(
  parameter int DEPTH = oai_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(oai_pkg::CAPACITY_DEF)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [oai_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [oai_pkg::DATA_W-1:0] rdata
);
  import oai_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/oai_ctrl.sv */
`timescale 1ns / 1ps
module oai_ctrl #(
  parameter int CAPACITY = oai_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(oai_pkg::CAPACITY_DEF),
  parameter int CW       = $clog2(oai_pkg::CAPACITY_DEF + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [oai_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [oai_pkg::DATA_W-1:0] in_value,
  input  logic signed [oai_pkg::POS_W-1:0]  in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oai_pkg::STAT_W-1:0]        out_status,
  output logic signed [oai_pkg::IDX_W-1:0]  out_result_index,
  output logic [oai_pkg::CNT_W-1:0]         out_element_count,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [oai_pkg::DATA_W-1:0]        mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [oai_pkg::DATA_W-1:0]        mem_rdata
);
  import oai_pkg::*;

  localparam int PW = (CW > 8) ? CW : 8;

  oai_state_t        state_r, state_nxt;
  oai_req_t          req_r, req_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     at_r, at_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  oai_status_t       res_status_r, res_status_nxt;
  logic [AW-1:0]     res_idx_r, res_idx_nxt;
  logic              res_none_r, res_none_nxt;
  logic              out_valid_r, out_valid_nxt;
  oai_status_t       out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              full;
  logic              pos_neg;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic [AW-1:0]     add_at;
  logic [AW-1:0]     rem_at;
  logic [AW-1:0]     last_addr;
  logic [CW-1:0]     rem_next;

  always_comb begin
    full      = (count_r >= CW'(CAPACITY));
    pos_neg   = pos_r[POS_W-1];
    pos_ext   = PW'(pos_r[7:0]);
    cnt_ext   = PW'(count_r);
    last_addr = AW'(count_r - 1'b1);
    if (req_r == REQ_INSERT && !pos_neg && pos_ext <= cnt_ext) begin
      add_at = AW'(pos_ext);
    end else begin
      add_at = AW'(count_r);
    end
    if (!pos_neg && pos_ext < cnt_ext) begin
      rem_at = AW'(pos_ext);
    end else begin
      rem_at = last_addr;
    end
    rem_next = CW'(rem_at) + 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    at_nxt         = at_r;
    ptr_nxt        = ptr_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = ptr_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_none_nxt   = res_none_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = at_r;
    mem_wdata      = value_r;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = oai_req_t'(in_req_type);
          value_nxt = in_value;
          pos_nxt   = in_position;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        issue_nxt = 1'b0;
        case (req_r)
          REQ_APPEND, REQ_INSERT: begin
            if (full) begin
              res_status_nxt = ST_FULL;
              res_none_nxt   = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              at_nxt    = add_at;
              ptr_nxt   = last_addr;
              issue_nxt = (CW'(add_at) < count_r);
              state_nxt = S_UP;
            end
          end
          REQ_REMOVE: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              res_none_nxt   = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              at_nxt    = rem_at;
              ptr_nxt   = AW'(rem_next);
              issue_nxt = (rem_next < count_r);
              state_nxt = S_DOWN;
            end
          end
          REQ_FIND: begin
            if (count_r == '0) begin
              res_status_nxt = ST_NOTFOUND;
              res_none_nxt   = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              ptr_nxt   = '0;
              issue_nxt = 1'b1;
              state_nxt = S_FIND;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_UP: begin
        mem_re        = issue_r;
        pend_nxt      = issue_r;
        pend_addr_nxt = ptr_r;
        if (issue_r) begin
          if (ptr_r == at_r) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r + 1'b1;
          mem_wdata = mem_rdata;
        end else if (!issue_r) begin
          mem_we         = 1'b1;
          mem_waddr      = at_r;
          mem_wdata      = value_r;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_OK;
          res_idx_nxt    = at_r;
          res_none_nxt   = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      S_DOWN: begin
        mem_re        = issue_r;
        pend_nxt      = issue_r;
        pend_addr_nxt = ptr_r;
        if (issue_r) begin
          if (ptr_r == last_addr) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r - 1'b1;
          mem_wdata = mem_rdata;
        end else if (!issue_r) begin
          count_nxt      = count_r - 1'b1;
          res_status_nxt = ST_OK;
          res_idx_nxt    = at_r;
          res_none_nxt   = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      S_FIND: begin
        mem_re        = issue_r;
        pend_nxt      = issue_r;
        pend_addr_nxt = ptr_r;
        if (issue_r) begin
          if (ptr_r == last_addr) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
        if (pend_r && mem_rdata == value_r) begin
          issue_nxt      = 1'b0;
          pend_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_idx_nxt    = pend_addr_r;
          res_none_nxt   = 1'b0;
          state_nxt      = S_DONE;
        end else if (!pend_r && !issue_r) begin
          res_status_nxt = ST_NOTFOUND;
          res_none_nxt   = 1'b1;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_none_r ? '1 : IDX_W'(res_idx_r);
          out_count_nxt  = CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    at_r         <= at_nxt;
    ptr_r        <= ptr_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_none_r   <= res_none_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_index  = out_index_r;
  assign out_element_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1
                      || count_r == $past(count_r) - 1'b1))
    else $error("Entry count moved by more than one.");

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("Shift wrote and read the same entry in one cycle.");

  a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_index_r == '1))
    else $error("Refused or unmatched transaction carries an index.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_W'(CAPACITY)))
    else $error("Full status reported below capacity.");

endmodule

/* rtl/ordered_array_insert_remove_find.sv */
`timescale 1ns / 1ps
// Append writes the value directly; a refused add, a remove on an empty array and a find
// on an empty array go straight to the result. Insert and remove shift the entries behind
// the position one at a time, and find compares the entries in order until a match.
// Throughput: one transaction at a time, set by the walk through the two-port entry memory;
// the next transaction is taken once the result is in the output register.
// Reset clears the entry count and handshake state; the entry memory is not cleared.
module ordered_array_insert_remove_find #(
  parameter int CAPACITY = oai_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [oai_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [oai_pkg::DATA_W-1:0] in_value,
  input  logic signed [oai_pkg::POS_W-1:0]  in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oai_pkg::STAT_W-1:0]        out_status,
  output logic signed [oai_pkg::IDX_W-1:0]  out_result_index,
  output logic [oai_pkg::CNT_W-1:0]         out_element_count
);
  import oai_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  oai_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_index  (out_result_index),
    .out_element_count (out_element_count),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  oai_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import oai_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = CAP + 16;

  typedef struct {
    oai_req_t                   kind;
    logic signed [DATA_W-1:0]   word;
    logic signed [POS_W-1:0]    pos;
  } array_req_t;

  typedef struct {
    oai_status_t                status;
    logic signed [IDX_W-1:0]    index;
    logic [CNT_W-1:0]           count;
  } array_resp_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [REQ_W-1:0]           in_req_type = '0;
  logic signed [DATA_W-1:0]   in_value = '0;
  logic signed [POS_W-1:0]    in_position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STAT_W-1:0]          out_status;
  logic signed [IDX_W-1:0]    out_result_index;
  logic [CNT_W-1:0]           out_element_count;

  array_req_t                 request_q[$];
  array_resp_t                response_due_q[$];
  array_req_t                 next_req;
  array_resp_t                due_resp;

  logic signed [DATA_W-1:0]   shadow_words[CAP];
  int                         shadow_count = 0;
  int                         planned_count = 0;
  logic signed [DATA_W-1:0]   word_pool[12];

  int                         burst_left = 0;
  int                         gap_left = 0;
  logic [15:0]                ready_pattern = 16'hFFFF;
  int                         pattern_age = 0;
  int                         stall_cycles = 0;
  int                         mismatch_count = 0;

  ordered_array_insert_remove_find dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_index  (out_result_index),
    .out_element_count (out_element_count)
  );

  always #2 clk = ~clk;

  function automatic array_resp_t apply_array_op(input oai_req_t kind,
                                                 input logic signed [DATA_W-1:0] word,
                                                 input logic signed [POS_W-1:0] pos);
    array_resp_t resp;
    int          at;
    int          i;
    resp.status = ST_OK;
    resp.index  = -1;
    if (kind == REQ_APPEND || kind == REQ_INSERT) begin
      if (shadow_count >= CAP) begin
        resp.status = ST_FULL;
      end else begin
        at = shadow_count;
        if (kind == REQ_INSERT && pos >= 0 && int'(pos) <= shadow_count) at = int'(pos);
        for (i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
        shadow_words[at] = word;
        shadow_count++;
        resp.index = at[IDX_W-1:0];
      end
    end else if (kind == REQ_REMOVE) begin
      if (shadow_count == 0) begin
        resp.status = ST_EMPTY;
      end else begin
        at = shadow_count - 1;
        if (pos >= 0 && int'(pos) < shadow_count) at = int'(pos);
        for (i = at; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
        shadow_count--;
        resp.index = at[IDX_W-1:0];
      end
    end else begin
      resp.status = ST_NOTFOUND;
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_words[i] == word) begin
          resp.status = ST_OK;
          resp.index  = i[IDX_W-1:0];
          break;
        end
      end
    end
    resp.count = shadow_count[CNT_W-1:0];
    return resp;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_request(input oai_req_t kind, input logic signed [DATA_W-1:0] word,
                               input logic signed [POS_W-1:0] pos);
    request_q.push_back('{kind, word, pos});
    if ((kind == REQ_APPEND || kind == REQ_INSERT) && planned_count < CAP) planned_count++;
    else if (kind == REQ_REMOVE && planned_count > 0) planned_count--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 99) < 60) return word_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return -1;
    if (r < 14) return POS_W'($urandom_range(0, 511));
    if (r < 20) return POS_W'($urandom_range(planned_count, 255));
    return POS_W'($urandom_range(0, (planned_count > 0) ? planned_count - 1 : 0));
  endfunction

  task automatic queue_random_phase(input int n, input int add_pct, input int remove_pct);
    int       r;
    oai_req_t kind;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) kind = ($urandom_range(0, 1) == 0) ? REQ_APPEND : REQ_INSERT;
      else if (r < add_pct + remove_pct) kind = REQ_REMOVE;
      else kind = REQ_FIND;
      queue_request(kind, pick_word(), pick_position());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() > 0) begin
        next_req = request_q.pop_front();
        in_req_type <= next_req.kind;
        in_value    <= next_req.word;
        in_position <= next_req.pos;
        in_valid    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          if ($urandom_range(0, 9) < 3) gap_left <= 0;
          else if ($urandom_range(0, 9) < 8) gap_left <= $urandom_range(1, 4);
          else gap_left <= $urandom_range(5, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      pattern_age <= 0;
    end else begin
      out_ready <= ready_pattern[0];
      if (pattern_age == 255) begin
        pattern_age <= 0;
        if ($urandom_range(0, 3) == 0) ready_pattern <= 16'hFFFF;
        else ready_pattern <= 16'($urandom) | 16'h0001;
      end else begin
        pattern_age   <= pattern_age + 1;
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (in_valid && in_ready)
        response_due_q.push_back(apply_array_op(oai_req_t'(in_req_type), in_value,
                                                in_position));
      if (out_valid && out_ready) begin
        if (response_due_q.size() == 0) begin
          flag_mismatch($sformatf("response with no transaction pending: status %0d",
                                  out_status));
        end else begin
          due_resp = response_due_q.pop_front();
          if (out_status !== due_resp.status)
            flag_mismatch($sformatf("status got %0d, want %0d", out_status,
                                    due_resp.status));
          if (out_result_index !== due_resp.index)
            flag_mismatch($sformatf("result_index got %0d, want %0d", out_result_index,
                                    due_resp.index));
          if (out_element_count !== due_resp.count)
            flag_mismatch($sformatf("element_count got %0d, want %0d", out_element_count,
                                    due_resp.count));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else if (request_q.size() > 0 || response_due_q.size() > 0 || in_valid)
        stall_cycles <= stall_cycles + 1;
      else stall_cycles <= 0;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    word_pool[0] = 32'sh7FFF_FFFF;
    word_pool[1] = 32'sh8000_0000;
    word_pool[2] = 0;
    word_pool[3] = -1;
    word_pool[4] = 1;
    word_pool[5] = 32'sh5555_5555;
    word_pool[6] = 32'shAAAA_AAAA;
    for (int k = 7; k < 12; k++) word_pool[k] = $urandom;

    // Directed opening: the empty array, the edges of the position field and duplicates.
    queue_request(REQ_REMOVE, 0, 0);
    queue_request(REQ_FIND, 0, 0);
    queue_request(REQ_APPEND, 32'sh7FFF_FFFF, 0);
    queue_request(REQ_APPEND, 32'sh8000_0000, 9'sh0FF);
    queue_request(REQ_INSERT, 0, 0);
    queue_request(REQ_INSERT, -1, POS_W'(planned_count));
    queue_request(REQ_INSERT, 1, 9'sh0FF);
    queue_request(REQ_INSERT, 32'sh5555_5555, -1);
    queue_request(REQ_INSERT, 32'shAAAA_AAAA, 9'sh100);
    queue_request(REQ_INSERT, 7, 2);
    queue_request(REQ_APPEND, 7, 0);
    queue_request(REQ_FIND, 32'sh8000_0000, 0);
    queue_request(REQ_FIND, 32'sh0001_2345, 0);
    queue_request(REQ_FIND, 7, 0);
    queue_request(REQ_FIND, -1, 0);
    queue_request(REQ_REMOVE, 0, -1);
    queue_request(REQ_REMOVE, 0, 0);
    queue_request(REQ_REMOVE, 0, 9'sh0FF);
    queue_request(REQ_REMOVE, 0, POS_W'(planned_count));
    queue_request(REQ_REMOVE, 0, 1);
    queue_request(REQ_REMOVE, 0, 9'sh100);
    queue_request(REQ_FIND, 7, 9'sh155);

    queue_random_phase(400, 88, 6);
    queue_random_phase(250, 40, 35);
    queue_random_phase(350, 6, 88);
    queue_random_phase(200, 45, 40);
    queue_random_phase(350, 85, 8);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || in_valid || response_due_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
